>>> design/zus_pkg.sv
// shared types and constants for the shrink lzw decoder
package zus_pkg;

	localparam int ACC_W   = 20;
	localparam int BITS_W  = 5;
	localparam int WIDTH_W = 4;
	localparam int CODE_W  = 13;
	localparam int PREV_W  = 14;
	localparam int LINK_W  = 15;
	localparam int FIRST_W = 9;
	localparam int RESULT_CAP = 64;

	localparam logic [CODE_W-1:0]  ESC_CODE   = 13'd256;
	localparam logic [CODE_W-1:0]  ESC_WIDEN  = 13'd1;
	localparam logic [CODE_W-1:0]  ESC_CLEAR  = 13'd2;
	localparam logic [LINK_W-1:0]  NO_PARENT  = 15'h2000;
	localparam logic [LINK_W-1:0]  BAD_LINK   = 15'h4000;
	localparam logic [PREV_W-1:0]  PREV_NONE  = 14'h2000;
	localparam logic [FIRST_W-1:0] FIRST_NONE = 9'h100;
	localparam logic [PREV_W-1:0]  FIRST_FREE = 14'd257;
	localparam logic [WIDTH_W-1:0] INIT_WIDTH = 4'd9;

	typedef enum logic [2:0] {
		ERR_NONE   = 3'd0,
		ERR_WIDTH  = 3'd1,
		ERR_ESCAPE = 3'd2,
		ERR_UNDEF  = 3'd3,
		ERR_LONG   = 3'd4,
		ERR_FULL   = 3'd5
	} err_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_TAKE,
		OP_DISPATCH,
		OP_WALK_RD,
		OP_WALK_ACT,
		OP_SCAN_RD,
		OP_SCAN_ACT,
		OP_COMMIT,
		OP_EMIT_RD,
		OP_EMIT_ACT,
		OP_EMIT_OUT,
		OP_ERR_OUT,
		OP_MARK_RD,
		OP_MARK_ACT,
		OP_FREE_RD,
		OP_FREE_ACT
	} op_t;

	typedef enum logic [2:0] {
		K_ESC_PREFIX,
		K_WIDEN,
		K_WIDEN_ERR,
		K_CLEAR,
		K_BAD_ESC,
		K_RANGE_ERR,
		K_WALK
	} kind_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  take_code;
		logic  walk_limit;
		logic  walk_range;
		logic  walk_undef;
		logic  walk_end;
		logic  prev_none;
		logic  slot_range;
		logic  slot_free;
		logic  emit_full;
		logic  emit_done;
		logic  can_load;
		logic  sweep_end;
		logic  init_end;
	} status_t;

endpackage

>>> design/zus_ram.sv
// generic single-write ram with registered read
module zus_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/zus_ctrl.sv
// sequencing state machine of the shrink lzw decoder
module zus_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  zus_pkg::status_t status,
	output zus_pkg::cmd_t    cmd
);

	typedef enum logic [4:0] {
		S_INIT, S_IDLE, S_DISPATCH, S_WALK_RD, S_WALK_ACT, S_SCAN_RD, S_SCAN_ACT,
		S_COMMIT, S_EMIT_RD, S_EMIT_ACT, S_EMIT_OUT, S_ERR, S_MARK_RD, S_MARK_ACT,
		S_FREE_RD, S_FREE_ACT
	} state_t;

	state_t state_q;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd.op = zus_pkg::OP_NONE;
		unique case (state_q)
			S_INIT:     cmd.op = zus_pkg::OP_INIT;
			S_IDLE:     cmd.op = s_tvalid ? zus_pkg::OP_TAKE : zus_pkg::OP_NONE;
			S_DISPATCH: cmd.op = zus_pkg::OP_DISPATCH;
			S_WALK_RD:  cmd.op = zus_pkg::OP_WALK_RD;
			S_WALK_ACT: cmd.op = zus_pkg::OP_WALK_ACT;
			S_SCAN_RD:  cmd.op = zus_pkg::OP_SCAN_RD;
			S_SCAN_ACT: cmd.op = zus_pkg::OP_SCAN_ACT;
			S_COMMIT:   cmd.op = zus_pkg::OP_COMMIT;
			S_EMIT_RD:  cmd.op = zus_pkg::OP_EMIT_RD;
			S_EMIT_ACT: cmd.op = zus_pkg::OP_EMIT_ACT;
			S_EMIT_OUT: cmd.op = zus_pkg::OP_EMIT_OUT;
			S_ERR:      cmd.op = zus_pkg::OP_ERR_OUT;
			S_MARK_RD:  cmd.op = zus_pkg::OP_MARK_RD;
			S_MARK_ACT: cmd.op = zus_pkg::OP_MARK_ACT;
			S_FREE_RD:  cmd.op = zus_pkg::OP_FREE_RD;
			S_FREE_ACT: cmd.op = zus_pkg::OP_FREE_ACT;
			default:    cmd.op = zus_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (status.init_end) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (s_tvalid && status.take_code) state_q <= S_DISPATCH;
				end
				S_DISPATCH: begin
					unique case (status.kind)
						zus_pkg::K_ESC_PREFIX, zus_pkg::K_WIDEN: state_q <= S_IDLE;
						zus_pkg::K_CLEAR: state_q <= S_MARK_RD;
						zus_pkg::K_WALK:  state_q <= S_WALK_RD;
						default:          state_q <= S_ERR;
					endcase
				end
				S_WALK_RD: begin
					state_q <= (status.walk_limit || status.walk_range) ? S_ERR : S_WALK_ACT;
				end
				S_WALK_ACT: begin
					if (status.walk_undef) state_q <= S_ERR;
					else if (!status.walk_end) state_q <= S_WALK_RD;
					else if (status.prev_none) state_q <= S_COMMIT;
					else state_q <= S_SCAN_RD;
				end
				S_SCAN_RD:  state_q <= status.slot_range ? S_ERR : S_SCAN_ACT;
				S_SCAN_ACT: state_q <= status.slot_free ? S_COMMIT : S_SCAN_RD;
				S_COMMIT:   state_q <= S_EMIT_RD;
				S_EMIT_RD:  state_q <= S_EMIT_ACT;
				S_EMIT_ACT: state_q <= status.emit_full ? S_EMIT_OUT : S_EMIT_RD;
				S_EMIT_OUT: begin
					if (status.can_load) state_q <= status.emit_done ? S_IDLE : S_EMIT_RD;
				end
				S_ERR: begin
					if (status.can_load) state_q <= S_IDLE;
				end
				S_MARK_RD:  state_q <= status.sweep_end ? S_FREE_RD : S_MARK_ACT;
				S_MARK_ACT: state_q <= S_MARK_RD;
				S_FREE_RD:  state_q <= status.sweep_end ? S_IDLE : S_FREE_ACT;
				S_FREE_ACT: state_q <= S_FREE_RD;
				default:    state_q <= S_INIT;
			endcase
		end
	end

endmodule

>>> design/zus_dpath.sv
// bit unpacking, code tables, string stack and result register
module zus_dpath #(
	parameter int CODE_COUNT       = 8192,
	parameter int MAX_CODE_BITS    = 13,
	parameter int STRING_MAX       = 512,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  zus_pkg::cmd_t    cmd,
	output zus_pkg::status_t status,
	input  logic [7:0]       s_tdata,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [71:0]      m_tdata,
	output logic             m_tlast
);

	localparam int AW = $clog2(CODE_COUNT);
	localparam int IW = AW + 1;
	localparam int CAP_BYTES = zus_pkg::RESULT_CAP * BYTES_PER_RESULT;
	localparam int STR_LIMIT = (STRING_MAX < CAP_BYTES) ? STRING_MAX : CAP_BYTES;
	localparam int CW = $clog2(STR_LIMIT + 1);
	localparam int SAW = $clog2(STRING_MAX);

	logic [zus_pkg::ACC_W-1:0]   acc_q;
	logic [zus_pkg::BITS_W-1:0]  bits_q;
	logic [zus_pkg::WIDTH_W-1:0] width_q;
	logic                        esc_q;
	logic [zus_pkg::CODE_W-1:0]  code_q;
	logic [zus_pkg::PREV_W-1:0]  prev_q;
	logic [zus_pkg::FIRST_W-1:0] pfb_q;
	logic [zus_pkg::PREV_W-1:0]  hint_q;
	logic [zus_pkg::PREV_W-1:0]  slot_q;
	logic [zus_pkg::LINK_W-1:0]  walk_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               rem_q;
	logic [7:0]                  first_q;
	logic [IW-1:0]               idx_q;
	zus_pkg::err_t               err_q;
	logic [3:0]                  j_q;
	logic [63:0]                 word_q;
	logic                        ovalid_q;
	logic [63:0]                 obytes_q;
	logic [3:0]                  ocount_q;
	logic                        olast_q;
	zus_pkg::err_t               oerr_q;

	logic [zus_pkg::ACC_W-1:0]  acc_or;
	logic [zus_pkg::ACC_W-1:0]  code_mask;
	logic [zus_pkg::ACC_W-1:0]  acc_code;
	logic [zus_pkg::BITS_W-1:0] bits_sum;
	logic                       take_code;

	logic [zus_pkg::LINK_W-1:0] link_rd;
	logic [7:0]                 byte_rd;
	logic                       mark_rd;
	logic [7:0]                 stack_rd;

	logic                       link_bad;
	logic [7:0]                 push_byte;
	logic [zus_pkg::LINK_W-1:0] walk_next;
	logic                       mark_hit;
	logic                       idx_low;
	logic                       can_load;
	logic [CW-1:0]              rem_dec;

	logic          tab_we, byte_we, link_we, mark_we, stack_we;
	logic [AW-1:0] tab_waddr, tab_raddr, mark_waddr;
	logic [7:0]    byte_wdata;
	logic [zus_pkg::LINK_W-1:0] link_wdata;

	// bit accumulator, least significant bit first
	assign acc_or    = acc_q | (zus_pkg::ACC_W'(s_tdata) << bits_q[3:0]);
	assign bits_sum  = bits_q + zus_pkg::BITS_W'(8);
	assign take_code = bits_sum >= {1'b0, width_q};
	assign code_mask = (zus_pkg::ACC_W'(1) << width_q) - zus_pkg::ACC_W'(1);
	assign acc_code  = acc_or & code_mask;

	assign link_bad  = link_rd == zus_pkg::BAD_LINK;
	assign push_byte = link_bad ? pfb_q[7:0] : byte_rd;
	assign walk_next = link_bad ? zus_pkg::LINK_W'(prev_q) : link_rd;
	assign mark_hit  = (link_rd != zus_pkg::NO_PARENT) && !link_bad
		&& (32'(link_rd) < CODE_COUNT);
	assign idx_low   = 32'(idx_q) < 256;
	assign can_load  = !ovalid_q || m_tready;
	assign rem_dec   = rem_q - CW'(1);

	always_comb begin
		status.take_code  = take_code;
		status.walk_limit = 32'(count_q) >= STR_LIMIT;
		status.walk_range = 32'(walk_q) >= CODE_COUNT;
		status.walk_undef = link_bad
			&& (prev_q == zus_pkg::PREV_NONE || pfb_q == zus_pkg::FIRST_NONE);
		status.walk_end   = walk_next == zus_pkg::NO_PARENT;
		status.prev_none  = prev_q == zus_pkg::PREV_NONE;
		status.slot_range = 32'(slot_q) >= CODE_COUNT;
		status.slot_free  = link_bad;
		status.emit_full  = (32'(j_q) + 1 == BYTES_PER_RESULT) || (rem_q == CW'(1));
		status.emit_done  = rem_q == '0;
		status.can_load   = can_load;
		status.sweep_end  = 32'(idx_q) >= CODE_COUNT;
		status.init_end   = 32'(idx_q) == CODE_COUNT - 1;
		if (esc_q) begin
			if (code_q == zus_pkg::ESC_WIDEN) begin
				status.kind = (32'(width_q) >= MAX_CODE_BITS) ? zus_pkg::K_WIDEN_ERR
					: zus_pkg::K_WIDEN;
			end else if (code_q == zus_pkg::ESC_CLEAR) begin
				status.kind = zus_pkg::K_CLEAR;
			end else begin
				status.kind = zus_pkg::K_BAD_ESC;
			end
		end else if (code_q == zus_pkg::ESC_CODE) begin
			status.kind = zus_pkg::K_ESC_PREFIX;
		end else if (32'(code_q) >= CODE_COUNT) begin
			status.kind = zus_pkg::K_RANGE_ERR;
		end else begin
			status.kind = zus_pkg::K_WALK;
		end
	end

	// table port muxing
	always_comb begin
		case (cmd.op)
			zus_pkg::OP_WALK_RD: tab_raddr = walk_q[AW-1:0];
			zus_pkg::OP_SCAN_RD: tab_raddr = slot_q[AW-1:0];
			default:             tab_raddr = idx_q[AW-1:0];
		endcase
		tab_we     = 1'b0;
		tab_waddr  = idx_q[AW-1:0];
		link_wdata = zus_pkg::BAD_LINK;
		byte_wdata = idx_low ? idx_q[7:0] : 8'd0;
		link_we    = 1'b0;
		case (cmd.op)
			zus_pkg::OP_INIT: begin
				tab_we     = 1'b1;
				link_we    = 1'b1;
				link_wdata = idx_low ? zus_pkg::NO_PARENT : zus_pkg::BAD_LINK;
			end
			zus_pkg::OP_SCAN_ACT: begin
				tab_we     = link_bad;
				link_we    = link_bad;
				tab_waddr  = slot_q[AW-1:0];
				link_wdata = zus_pkg::LINK_W'(prev_q);
				byte_wdata = first_q;
			end
			zus_pkg::OP_FREE_ACT: begin
				link_we = !mark_rd;
			end
			default: begin
				tab_we = 1'b0;
			end
		endcase
		byte_we    = tab_we;
		mark_we    = (cmd.op == zus_pkg::OP_INIT) || (cmd.op == zus_pkg::OP_FREE_ACT)
			|| ((cmd.op == zus_pkg::OP_MARK_ACT) && mark_hit);
		mark_waddr = (cmd.op == zus_pkg::OP_MARK_ACT) ? link_rd[AW-1:0] : idx_q[AW-1:0];
		stack_we   = (cmd.op == zus_pkg::OP_WALK_ACT) && !status.walk_undef;
	end

	zus_ram #(.WIDTH(zus_pkg::LINK_W), .DEPTH(CODE_COUNT)) u_link (
		.clk(clk), .we(link_we), .waddr(tab_waddr), .wdata(link_wdata),
		.raddr(tab_raddr), .rdata(link_rd)
	);

	zus_ram #(.WIDTH(8), .DEPTH(CODE_COUNT)) u_byte (
		.clk(clk), .we(byte_we), .waddr(tab_waddr), .wdata(byte_wdata),
		.raddr(tab_raddr), .rdata(byte_rd)
	);

	zus_ram #(.WIDTH(1), .DEPTH(CODE_COUNT)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_waddr),
		.wdata(cmd.op == zus_pkg::OP_MARK_ACT),
		.raddr(idx_q[AW-1:0]), .rdata(mark_rd)
	);

	zus_ram #(.WIDTH(8), .DEPTH(STRING_MAX)) u_stack (
		.clk(clk), .we(stack_we), .waddr(SAW'(count_q)), .wdata(push_byte),
		.raddr(SAW'(rem_dec)), .rdata(stack_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			bits_q   <= '0;
			width_q  <= zus_pkg::INIT_WIDTH;
			esc_q    <= 1'b0;
			prev_q   <= zus_pkg::PREV_NONE;
			pfb_q    <= zus_pkg::FIRST_NONE;
			hint_q   <= zus_pkg::FIRST_FREE;
			idx_q    <= '0;
			err_q    <= zus_pkg::ERR_NONE;
			ovalid_q <= 1'b0;
		end else begin
			// result register: load wins over the drain of the previous transfer
			if (((cmd.op == zus_pkg::OP_EMIT_OUT) || (cmd.op == zus_pkg::OP_ERR_OUT))
				&& can_load) begin
				ovalid_q <= 1'b1;
			end else if (ovalid_q && m_tready) begin
				ovalid_q <= 1'b0;
			end
			case (cmd.op)
				zus_pkg::OP_INIT: idx_q <= idx_q + IW'(1);
				zus_pkg::OP_TAKE: begin
					if (take_code) begin
						acc_q  <= acc_or >> width_q;
						bits_q <= bits_sum - {1'b0, width_q};
					end else begin
						acc_q  <= acc_or;
						bits_q <= bits_sum;
					end
				end
				zus_pkg::OP_DISPATCH: begin
					case (status.kind)
						zus_pkg::K_ESC_PREFIX: esc_q <= 1'b1;
						zus_pkg::K_WIDEN: begin
							esc_q   <= 1'b0;
							width_q <= width_q + zus_pkg::WIDTH_W'(1);
						end
						zus_pkg::K_WIDEN_ERR: begin
							esc_q <= 1'b0;
							err_q <= zus_pkg::ERR_WIDTH;
						end
						zus_pkg::K_BAD_ESC: begin
							esc_q <= 1'b0;
							err_q <= zus_pkg::ERR_ESCAPE;
						end
						zus_pkg::K_CLEAR: begin
							esc_q <= 1'b0;
							idx_q <= IW'(zus_pkg::FIRST_FREE);
						end
						zus_pkg::K_RANGE_ERR: err_q <= zus_pkg::ERR_UNDEF;
						default: begin
							err_q <= zus_pkg::ERR_NONE;
						end
					endcase
				end
				zus_pkg::OP_WALK_RD: begin
					err_q <= status.walk_limit ? zus_pkg::ERR_LONG : zus_pkg::ERR_UNDEF;
				end
				zus_pkg::OP_WALK_ACT: begin
					if (status.walk_undef) err_q <= zus_pkg::ERR_UNDEF;
				end
				zus_pkg::OP_SCAN_RD: err_q <= zus_pkg::ERR_FULL;
				zus_pkg::OP_SCAN_ACT: begin
					if (link_bad) hint_q <= slot_q + zus_pkg::PREV_W'(1);
				end
				zus_pkg::OP_COMMIT: begin
					prev_q <= zus_pkg::PREV_W'(code_q);
					pfb_q  <= {1'b0, first_q};
				end
				zus_pkg::OP_MARK_RD: begin
					if (status.sweep_end) idx_q <= IW'(zus_pkg::FIRST_FREE);
				end
				zus_pkg::OP_MARK_ACT: idx_q <= idx_q + IW'(1);
				zus_pkg::OP_FREE_RD: begin
					if (status.sweep_end) hint_q <= zus_pkg::FIRST_FREE;
				end
				zus_pkg::OP_FREE_ACT: idx_q <= idx_q + IW'(1);
				default: begin
					err_q <= err_q;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			zus_pkg::OP_TAKE: begin
				if (take_code) code_q <= acc_code[zus_pkg::CODE_W-1:0];
			end
			zus_pkg::OP_DISPATCH: begin
				walk_q  <= zus_pkg::LINK_W'(code_q);
				count_q <= '0;
			end
			zus_pkg::OP_WALK_ACT: begin
				count_q <= count_q + CW'(1);
				first_q <= push_byte;
				walk_q  <= walk_next;
				slot_q  <= hint_q;
			end
			zus_pkg::OP_SCAN_ACT: begin
				if (!link_bad) slot_q <= slot_q + zus_pkg::PREV_W'(1);
			end
			zus_pkg::OP_COMMIT: begin
				rem_q  <= count_q;
				j_q    <= '0;
				word_q <= '0;
			end
			zus_pkg::OP_EMIT_ACT: begin
				word_q[j_q[2:0]*8 +: 8] <= stack_rd;
				j_q   <= j_q + 4'd1;
				rem_q <= rem_dec;
			end
			zus_pkg::OP_EMIT_OUT: begin
				if (can_load) begin
					obytes_q <= word_q;
					ocount_q <= j_q;
					olast_q  <= rem_q == '0;
					oerr_q   <= zus_pkg::ERR_NONE;
					word_q   <= '0;
					j_q      <= '0;
				end
			end
			zus_pkg::OP_ERR_OUT: begin
				if (can_load) begin
					obytes_q <= '0;
					ocount_q <= '0;
					olast_q  <= 1'b1;
					oerr_q   <= err_q;
				end
			end
			default: begin
				code_q <= code_q;
			end
		endcase
	end

	assign m_tvalid = ovalid_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {1'b0, oerr_q, ocount_q, obytes_q};

endmodule

>>> design/zip_unshrink_decoder.sv
// a code walks its chain with a read and an act step per decoded byte, then, if there is
// a previous code, probes slots the same way for a free one, unstacks its bytes and hands
// out each result transfer; input transfers are taken one at a time, only while idle;
// a byte without a full code, an escape prefix or a widen code goes straight back to idle
// a partial clear sweeps the entries from FIRST_FREE up twice, a mark pass then a free pass
// after reset a clearing pass over all CODE_COUNT entries fills the tables before s_tready rises
// reset: asynchronous active-low arst_n clears all control state
module zip_unshrink_decoder #(
	parameter int CODE_COUNT       = 8192,
	parameter int MAX_CODE_BITS    = 13,
	parameter int STRING_MAX       = 512,
	parameter int BYTES_PER_RESULT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte[7:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // out_bytes[63:0], byte_count[67:64], error_code[70:68]
	output logic        m_tlast    // last_of_string
);

	// command and status between sequencer and datapath
	zus_pkg::cmd_t    cmd;
	zus_pkg::status_t status;

	zus_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// tables, string stack and the result register live here
	zus_dpath #(
		.CODE_COUNT       (CODE_COUNT),
		.MAX_CODE_BITS    (MAX_CODE_BITS),
		.STRING_MAX       (STRING_MAX),
		.BYTES_PER_RESULT (BYTES_PER_RESULT)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// an error result carries no bytes and closes its string
	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[70:68] != 3'd0) |-> (m_tdata[67:64] == 4'd0) && m_tlast)
		else $error("error result with data");

	// a good result carries between one and BYTES_PER_RESULT bytes
	a_ok_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[70:68] == 3'd0) |->
		(m_tdata[67:64] != 4'd0) && (32'(m_tdata[67:64]) <= BYTES_PER_RESULT))
		else $error("bad byte count");

	// while s_tready is high the sequencer issues only a take command or none
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (cmd.op == zus_pkg::OP_TAKE) || (cmd.op == zus_pkg::OP_NONE))
		else $error("input taken outside idle");

endmodule
